// ===== src/lpg_pkg.sv =====
package lpg_pkg;

    localparam int unsigned COORD_W  = 16;
    localparam int unsigned COLOUR_W = 32;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RUN   = 2'd1,
        PH_FINAL = 2'd2
    } phase_t;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } op_t;

    typedef struct packed {
        logic                       valid_res;
        logic signed [COORD_W-1:0]  pixel_x;
        logic signed [COORD_W-1:0]  pixel_y;
        logic        [COLOUR_W-1:0] colour_out;
        logic                       last;
    } res_t;

endpackage

// ===== src/lpg_if.sv =====
interface lpg_req_if;
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic signed [lpg_pkg::COORD_W-1:0]  start_x;
    logic signed [lpg_pkg::COORD_W-1:0]  start_y;
    logic signed [lpg_pkg::COORD_W-1:0]  end_x;
    logic signed [lpg_pkg::COORD_W-1:0]  end_y;
    logic        [lpg_pkg::COLOUR_W-1:0] colour;
    logic                                inclusive;

    modport source (
        output valid, op, start_x, start_y, end_x, end_y, colour, inclusive,
        input  ready
    );
    modport sink (
        input  valid, op, start_x, start_y, end_x, end_y, colour, inclusive,
        output ready
    );
endinterface

interface lpg_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                valid_res;
    logic signed [lpg_pkg::COORD_W-1:0]  pixel_x;
    logic signed [lpg_pkg::COORD_W-1:0]  pixel_y;
    logic        [lpg_pkg::COLOUR_W-1:0] colour_out;
    logic                                last;

    modport source (
        output valid, valid_res, pixel_x, pixel_y, colour_out, last,
        input  ready
    );
    modport sink (
        input  valid, valid_res, pixel_x, pixel_y, colour_out, last,
        output ready
    );
endinterface

// ===== src/lpg_out_buf.sv =====
module lpg_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lpg_pkg::res_t    push_data,
    output logic             space,
    lpg_rsp_if.source        rsp
);

    logic          out_valid_reg, out_valid_next;
    lpg_pkg::res_t out_data_reg, out_data_next;
    logic          skid_valid_reg, skid_valid_next;
    lpg_pkg::res_t skid_data_reg, skid_data_next;
    logic          take;

    assign take  = out_valid_reg && rsp.ready;
    assign space = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                // The skid entry moves up; no push can arrive while it is full.
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_data_next = push_data;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg)
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
            else
            begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.valid_res  = out_data_reg.valid_res;
    assign rsp.pixel_x    = out_data_reg.pixel_x;
    assign rsp.pixel_y    = out_data_reg.pixel_y;
    assign rsp.colour_out = out_data_reg.colour_out;
    assign rsp.last       = out_data_reg.last;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register is empty");

    a_stalled_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready |=> out_valid_reg && $stable(out_data_reg))
        else $error("stalled result changed");

endmodule

// ===== src/line_point_generator_core.sv =====
// Channel | Direction | Transaction                  | Payload
// req     | in        | req.valid & req.ready        | op, endpoints, colour, inclusive
// rsp     | out       | rsp.valid & rsp.ready        | valid_res, pixel_x/y, colour_out, last
//
// One request transaction is taken per cycle; a step request's result is registered in
// the output buffer and a load request gives none. Each step is one compare-and-add pass
// over the registered error term and step counters, with no multiplier in the loop.
// Reset (rst_n low, asynchronous) leaves no line pending and the output buffer empty.
// A two-entry output buffer holds results while rsp stalls; req.ready drops only when
// both entries are occupied.
module line_point_generator_core #(
    parameter int COORD_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    lpg_req_if.sink   req,
    lpg_rsp_if.source rsp
);

    localparam int CB    = COORD_BITS;
    localparam int EXT_W = (CB > 16) ? CB : 16;
    localparam int D_W   = CB + 2;

    typedef logic signed [CB-1:0]  coord_t;
    typedef logic signed [CB:0]    delta_t;
    typedef logic        [CB-1:0]  inc_t;
    typedef logic        [CB:0]    cnt_t;
    typedef logic signed [D_W-1:0] err_t;

    // Line state.
    lpg_pkg::phase_t                  phase_reg, phase_next;
    coord_t                           cur_x_reg, cur_x_next;
    coord_t                           cur_y_reg, cur_y_next;
    logic                             mv_x_reg, mv_x_next;
    logic                             neg_x_reg, neg_x_next;
    logic                             mv_y_reg, mv_y_next;
    logic                             neg_y_reg, neg_y_next;
    inc_t                             inc_x_reg, inc_x_next;
    inc_t                             inc_y_reg, inc_y_next;
    err_t                             err_reg, err_next;
    cnt_t                             nx_reg, nx_next;
    cnt_t                             ny_reg, ny_next;
    logic [lpg_pkg::COLOUR_W-1:0]     colour_reg, colour_next;
    logic                             want_final_reg, want_final_next;

    logic          accept;
    logic          buf_space;
    logic          push;
    lpg_pkg::res_t res;

    // Load path.
    logic [EXT_W-1:0] sx_ext, sy_ext, ex_ext, ey_ext;
    coord_t           sx, sy, ex, ey;
    delta_t           dx, dy;
    delta_t           adx, ady;
    inc_t             mag_x, mag_y;
    inc_t             ld_inc_x, ld_inc_y;

    // Step path.
    logic   y_step, x_step;
    err_t   err_mid;
    cnt_t   nx_upd, ny_upd;
    logic   more;

    assign accept = req.valid && req.ready;
    assign push   = accept && (req.op == lpg_pkg::OP_STEP);

    // Coordinates are the low COORD_BITS of the 16-bit field read as signed.
    assign sx_ext = EXT_W'($unsigned(req.start_x));
    assign sy_ext = EXT_W'($unsigned(req.start_y));
    assign ex_ext = EXT_W'($unsigned(req.end_x));
    assign ey_ext = EXT_W'($unsigned(req.end_y));
    assign sx     = coord_t'(sx_ext[CB-1:0]);
    assign sy     = coord_t'(sy_ext[CB-1:0]);
    assign ex     = coord_t'(ex_ext[CB-1:0]);
    assign ey     = coord_t'(ey_ext[CB-1:0]);
    assign dx     = delta_t'(ex) - delta_t'(sx);
    assign dy     = delta_t'(ey) - delta_t'(sy);
    assign adx    = dx[CB] ? -dx : dx;
    assign ady    = dy[CB] ? -dy : dy;
    assign mag_y  = adx[CB-1:0];
    assign mag_x  = ady[CB-1:0];
    assign ld_inc_x = (mag_x == '0) ? mag_y : mag_x;
    assign ld_inc_y = (mag_y == '0) ? mag_x : mag_y;

    // The accumulators are tracked as their difference (acc_x - acc_y) plus the number of
    // increments each has taken, so acc <= inc_x * inc_y becomes a count compare.
    assign y_step  = !err_reg[D_W-1];
    assign err_mid = y_step ? err_reg - err_t'(inc_y_reg) : err_reg;
    assign x_step  = err_mid[D_W-1] || (err_mid == '0);
    assign ny_upd  = y_step ? ny_reg + cnt_t'(1) : ny_reg;
    assign nx_upd  = x_step ? nx_reg + cnt_t'(1) : nx_reg;
    assign more    = (nx_upd <= cnt_t'(inc_y_reg)) && (ny_upd <= cnt_t'(inc_x_reg));

    always_comb
    begin
        phase_next      = phase_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        mv_x_next       = mv_x_reg;
        neg_x_next      = neg_x_reg;
        mv_y_next       = mv_y_reg;
        neg_y_next      = neg_y_reg;
        inc_x_next      = inc_x_reg;
        inc_y_next      = inc_y_reg;
        err_next        = err_reg;
        nx_next         = nx_reg;
        ny_next         = ny_reg;
        colour_next     = colour_reg;
        want_final_next = want_final_reg;
        res             = '0;

        if (accept && (req.op == lpg_pkg::OP_LOAD))
        begin
            cur_x_next      = sx;
            cur_y_next      = sy;
            mv_x_next       = (dx != '0);
            neg_x_next      = dx[CB];
            mv_y_next       = (dy != '0);
            neg_y_next      = dy[CB];
            inc_x_next      = ld_inc_x;
            inc_y_next      = ld_inc_y;
            err_next        = err_t'(ld_inc_x) - err_t'(ld_inc_y);
            nx_next         = cnt_t'(1);
            ny_next         = cnt_t'(1);
            colour_next     = req.colour;
            want_final_next = req.inclusive;
            if ((mag_x != '0) || (mag_y != '0))
            begin
                phase_next = lpg_pkg::PH_RUN;
            end
            else if (req.inclusive)
            begin
                phase_next = lpg_pkg::PH_FINAL;
            end
            else
            begin
                phase_next = lpg_pkg::PH_IDLE;
            end
        end
        else if (push)
        begin
            unique case (phase_reg)
                lpg_pkg::PH_RUN:
                begin
                    res.valid_res  = 1'b1;
                    res.pixel_x    = lpg_pkg::COORD_W'(cur_x_reg);
                    res.pixel_y    = lpg_pkg::COORD_W'(cur_y_reg);
                    res.colour_out = colour_reg;
                    if (y_step && mv_y_reg)
                    begin
                        cur_y_next = neg_y_reg ? cur_y_reg - coord_t'(1)
                                               : cur_y_reg + coord_t'(1);
                    end
                    if (x_step && mv_x_reg)
                    begin
                        cur_x_next = neg_x_reg ? cur_x_reg - coord_t'(1)
                                               : cur_x_reg + coord_t'(1);
                    end
                    err_next = x_step ? err_mid + err_t'(inc_x_reg) : err_mid;
                    nx_next  = nx_upd;
                    ny_next  = ny_upd;
                    if (!more)
                    begin
                        if (want_final_reg)
                        begin
                            phase_next = lpg_pkg::PH_FINAL;
                        end
                        else
                        begin
                            res.last   = 1'b1;
                            phase_next = lpg_pkg::PH_IDLE;
                        end
                    end
                end
                lpg_pkg::PH_FINAL:
                begin
                    res.valid_res  = 1'b1;
                    res.pixel_x    = lpg_pkg::COORD_W'(cur_x_reg);
                    res.pixel_y    = lpg_pkg::COORD_W'(cur_y_reg);
                    res.colour_out = colour_reg;
                    res.last       = 1'b1;
                    phase_next     = lpg_pkg::PH_IDLE;
                end
                default:
                begin
                    phase_next = lpg_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= lpg_pkg::PH_IDLE;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            mv_x_reg       <= 1'b0;
            neg_x_reg      <= 1'b0;
            mv_y_reg       <= 1'b0;
            neg_y_reg      <= 1'b0;
            inc_x_reg      <= '0;
            inc_y_reg      <= '0;
            err_reg        <= '0;
            nx_reg         <= '0;
            ny_reg         <= '0;
            colour_reg     <= '0;
            want_final_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            mv_x_reg       <= mv_x_next;
            neg_x_reg      <= neg_x_next;
            mv_y_reg       <= mv_y_next;
            neg_y_reg      <= neg_y_next;
            inc_x_reg      <= inc_x_next;
            inc_y_reg      <= inc_y_next;
            err_reg        <= err_next;
            nx_reg         <= nx_next;
            ny_reg         <= ny_next;
            colour_reg     <= colour_next;
            want_final_reg <= want_final_next;
        end
    end

    lpg_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .space     (buf_space),
        .rsp       (rsp)
    );

    assign req.ready = buf_space;

    a_run_incs_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == lpg_pkg::PH_RUN |-> (inc_x_reg != '0) && (inc_y_reg != '0))
        else $error("line stepping with a zero increment");

    a_run_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == lpg_pkg::PH_RUN
            |-> (nx_reg <= cnt_t'(inc_y_reg)) && (ny_reg <= cnt_t'(inc_x_reg)))
        else $error("step counter passed the limit while running");

    a_err_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == lpg_pkg::PH_RUN
            |-> (err_reg <= err_t'(inc_x_reg)) && (err_reg >= -err_t'(inc_y_reg)))
        else $error("error term out of range");

    a_load_gives_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.op == lpg_pkg::OP_LOAD) && !rsp.valid |=> !rsp.valid)
        else $error("load produced a result");

endmodule
